// ===== rtl/core/ovn_pkg.sv =====
// Shared constants and types for the octave value noise generator.
// No dependencies; every other file refers to it by scoped names.
package ovn_pkg;

   localparam int unsigned MAX_OCTAVES_DEF = 8;

   localparam int unsigned POS_W     = 32;
   localparam int unsigned OUT_W     = 32;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned PERS_W    = 18;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 18;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

   localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 4'd5;
   localparam logic [PERS_W-1:0]  PERSISTENCE_RST  = 18'd65536;

   // Internal arithmetic widths.
   localparam int unsigned FRAC_W    = 17;  // signed fraction, Q.16
   localparam int unsigned WEIGHT_W  = 20;  // signed smoothstep weight, Q.16
   localparam int unsigned VALUE_W   = 32;  // signed lattice value, Q2.30
   localparam int unsigned BLEND_W   = 30;  // signed blend, Q.24
   localparam int unsigned AMP_W     = 31;  // unsigned amplitude, Q.16
   localparam int unsigned CONTRIB_W = 46;  // signed octave contribution, Q.24
   localparam int unsigned SUM_W     = CONTRIB_W + 4;

   // Lane stages plus the summing stages.
   localparam int unsigned LANE_DEPTH = 8;
   localparam int unsigned SUM_DEPTH  = 3;
   localparam int unsigned PIPE_DEPTH = LANE_DEPTH + SUM_DEPTH;

   // Integer hash constants.
   localparam int unsigned HASH_SHIFT  = 13;
   localparam logic [31:0] HASH_MUL_A  = 32'd15731;
   localparam logic [31:0] HASH_ADD_B  = 32'd789221;
   localparam logic [31:0] HASH_ADD_C  = 32'd1376312589;
   localparam logic [31:0] LATTICE_ONE = 32'h4000_0000;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 20'sd65536;

   typedef logic [AMP_W-1:0]            amp_type;
   typedef logic signed [CONTRIB_W-1:0] contrib_type;

endpackage

// ===== rtl/core/ovn_if.sv =====
// Valid/ready channel interfaces for positions in and noise sums out.
// Depends on ovn_pkg for the payload widths.
interface ovn_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [ovn_pkg::POS_W-1:0]   position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

interface ovn_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ovn_pkg::OUT_W-1:0]   noise_sum;
   logic                               saturated;

   modport source (output valid, output noise_sum, output saturated, input ready);
   modport sink   (input valid, input noise_sum, input saturated, output ready);
endinterface

// ===== rtl/core/ovn_lane.sv =====
// One octave lane: lattice hash, smoothstep blend and amplitude scaling.
// Eight register stages, all advanced together; depends on ovn_pkg.
module ovn_lane #(
   parameter int unsigned EXP = 1
) (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic signed [ovn_pkg::POS_W-1:0]       position,
   input  ovn_pkg::amp_type                       amp,
   output ovn_pkg::contrib_type                   contrib
);

   // Stage 1: scale, truncate toward zero, start the hash.
   logic signed [39:0] pos_ext;
   logic signed [39:0] scaled;
   logic               round_up;
   logic [31:0]        ix0;
   logic [31:0]        ix1;
   logic signed [ovn_pkg::FRAC_W-1:0] t_in;

   assign pos_ext  = {{8{position[31]}}, position};
   assign scaled   = pos_ext <<< EXP;
   // A negative position with a nonzero fraction rounds its index up toward zero.
   assign round_up = scaled[39] && (scaled[15:0] != 16'd0);
   assign ix0      = {{8{scaled[39]}}, scaled[39:16]} + {31'd0, round_up};
   assign ix1      = ix0 + 32'd1;
   assign t_in     = {round_up, scaled[15:0]};

   logic signed [ovn_pkg::FRAC_W-1:0] t1_ff;
   logic [31:0] n0_1_ff, n1_1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= t_in;
         n0_1_ff <= (ix0 << ovn_pkg::HASH_SHIFT) ^ ix0;
         n1_1_ff <= (ix1 << ovn_pkg::HASH_SHIFT) ^ ix1;
      end
   end

   // Stage 2: t squared, n squared.
   logic signed [2*ovn_pkg::FRAC_W-1:0] t2_full;
   logic [63:0] sq0_full, sq1_full;
   assign t2_full  = t1_ff * t1_ff;
   assign sq0_full = n0_1_ff * n0_1_ff;
   assign sq1_full = n1_1_ff * n1_1_ff;

   logic signed [ovn_pkg::FRAC_W-1:0] t2t_ff;
   logic [31:0] t2_2_ff, n0_2_ff, n1_2_ff, sq0_2_ff, sq1_2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t2t_ff   <= t1_ff;
         t2_2_ff  <= t2_full[31:0];
         n0_2_ff  <= n0_1_ff;
         n1_2_ff  <= n1_1_ff;
         sq0_2_ff <= sq0_full[31:0];
         sq1_2_ff <= sq1_full[31:0];
      end
   end

   // Stage 3: t cubed, inner hash term.
   logic signed [49:0] t3_full;
   logic [63:0] m0_full, m1_full;
   assign t3_full = $signed({1'b0, t2_2_ff}) * t2t_ff;
   assign m0_full = sq0_2_ff * ovn_pkg::HASH_MUL_A;
   assign m1_full = sq1_2_ff * ovn_pkg::HASH_MUL_A;

   logic [31:0] t2_3_ff, n0_3_ff, n1_3_ff, m0_3_ff, m1_3_ff;
   logic signed [49:0] t3_3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_3_ff <= t2_2_ff;
         t3_3_ff <= t3_full;
         n0_3_ff <= n0_2_ff;
         n1_3_ff <= n1_2_ff;
         m0_3_ff <= m0_full[31:0] + ovn_pkg::HASH_ADD_B;
         m1_3_ff <= m1_full[31:0] + ovn_pkg::HASH_ADD_B;
      end
   end

   // Stage 4: smoothstep weight and lattice values.
   logic signed [53:0] w_p, w_n, w_sum;
   logic [63:0] h0_full, h1_full;
   logic [31:0] h0, h1;

   assign w_p     = $signed({6'd0, t2_3_ff, 16'd0});
   assign w_n     = {{4{t3_3_ff[49]}}, t3_3_ff};
   assign w_sum   = w_p + (w_p <<< 1) - (w_n <<< 1) + (54'sd1 <<< 31);
   assign h0_full = n0_3_ff * m0_3_ff;
   assign h1_full = n1_3_ff * m1_3_ff;
   assign h0      = h0_full[31:0] + ovn_pkg::HASH_ADD_C;
   assign h1      = h1_full[31:0] + ovn_pkg::HASH_ADD_C;

   logic signed [ovn_pkg::WEIGHT_W-1:0] d4_ff;
   logic signed [ovn_pkg::VALUE_W-1:0]  v0_4_ff, v1_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d4_ff   <= w_sum[51:32];
         v0_4_ff <= $signed(ovn_pkg::LATTICE_ONE - {1'b0, h0[30:0]});
         v1_4_ff <= $signed(ovn_pkg::LATTICE_ONE - {1'b0, h1[30:0]});
      end
   end

   // Stage 5: weighted lattice values.
   logic signed [ovn_pkg::WEIGHT_W-1:0] a16;
   logic signed [51:0] p0_full, p1_full;
   assign a16     = ovn_pkg::WEIGHT_ONE - d4_ff;
   assign p0_full = a16 * v0_4_ff;
   assign p1_full = d4_ff * v1_4_ff;

   logic signed [51:0] p0_5_ff, p1_5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_5_ff <= p0_full;
         p1_5_ff <= p1_full;
      end
   end

   // Stage 6: blend, rounded to Q.24.
   logic signed [52:0] blend_sum;
   assign blend_sum = {p0_5_ff[51], p0_5_ff} + {p1_5_ff[51], p1_5_ff} + (53'sd1 <<< 21);

   logic signed [ovn_pkg::BLEND_W-1:0] blend_6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         blend_6_ff <= blend_sum[51:22];
      end
   end

   // Stage 7: amplitude product.
   logic signed [61:0] scaled_full;
   assign scaled_full = blend_6_ff * $signed({1'b0, amp});

   logic signed [61:0] prod_7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_7_ff <= scaled_full;
      end
   end

   // Stage 8: round back to Q.24.
   logic signed [61:0] prod_rnd;
   assign prod_rnd = prod_7_ff + (62'sd1 <<< 15);

   logic signed [ovn_pkg::CONTRIB_W-1:0] contrib_8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         contrib_8_ff <= prod_rnd[61:16];
      end
   end

   assign contrib = contrib_8_ff;

endmodule

// ===== rtl/core/ovn_amp.sv =====
// Per-octave amplitude table, recomputed after each persistence write.
// One shared multiplier, one entry per cycle; depends on ovn_pkg.
module ovn_amp #(
   parameter int unsigned NUM_LANES = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pers_write,
   input  logic [ovn_pkg::PERS_W-1:0]        pers_data,
   output ovn_pkg::amp_type                  amp [NUM_LANES],
   output logic                              busy
);

   localparam int unsigned CNT_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

   logic [ovn_pkg::PERS_W-1:0] pers_ff;
   ovn_pkg::amp_type           amp_ff [NUM_LANES];
   logic                       busy_ff;
   logic [CNT_W-1:0]           src_ff;

   logic [ovn_pkg::AMP_W+ovn_pkg::PERS_W-1:0] prod;
   logic [ovn_pkg::AMP_W+ovn_pkg::PERS_W-1:0] prod_rnd;

   assign prod     = amp_ff[src_ff] * pers_ff;
   assign prod_rnd = prod + ((ovn_pkg::AMP_W + ovn_pkg::PERS_W)'(1) << 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         pers_ff <= ovn_pkg::PERSISTENCE_RST;
         busy_ff <= 1'b0;
         src_ff  <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            amp_ff[i] <= ovn_pkg::AMP_W'(ovn_pkg::PERSISTENCE_RST);
         end
      end else if (pers_write) begin
         pers_ff   <= pers_data;
         amp_ff[0] <= ovn_pkg::AMP_W'(pers_data);
         busy_ff   <= (NUM_LANES > 1);
         src_ff    <= '0;
      end else if (busy_ff) begin
         // Each entry is the previous one times persistence, rounded to Q.16.
         if (NUM_LANES > 1) begin
            amp_ff[CNT_W'(src_ff + 1'b1)] <= prod_rnd[ovn_pkg::AMP_W+15:16];
         end
         src_ff <= src_ff + 1'b1;
         if (src_ff == CNT_W'(NUM_LANES - 2)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign amp  = amp_ff;
   assign busy = busy_ff;

endmodule

// ===== rtl/core/ovn_sum.sv =====
// Masked octave sum with saturation to the signed 32-bit range.
// Three register stages; depends on ovn_pkg.
module ovn_sum #(
   parameter int unsigned NUM_OCT = 8
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [ovn_pkg::COUNT_W-1:0]         octave_count,
   input  ovn_pkg::contrib_type                oct_contrib [NUM_OCT],
   output logic signed [ovn_pkg::OUT_W-1:0]    noise_sum,
   output logic                                saturated
);

   localparam int unsigned NUM_PAIRS = (NUM_OCT + 1) / 2;

   logic signed [ovn_pkg::SUM_W-1:0] pair_in [NUM_PAIRS];
   logic signed [ovn_pkg::SUM_W-1:0] pair_ff [NUM_PAIRS];

   // Octaves at or above the configured count contribute nothing.
   for (genvar j = 0; j < NUM_PAIRS; j++) begin : g_pair
      logic signed [ovn_pkg::SUM_W-1:0] lo;
      logic signed [ovn_pkg::SUM_W-1:0] hi;
      assign lo = (octave_count > ovn_pkg::COUNT_W'(2*j))
                  ? ovn_pkg::SUM_W'(oct_contrib[2*j]) : '0;
      if (2*j + 1 < NUM_OCT) begin : g_hi
         assign hi = (octave_count > ovn_pkg::COUNT_W'(2*j + 1))
                     ? ovn_pkg::SUM_W'(oct_contrib[2*j+1]) : '0;
      end else begin : g_nohi
         assign hi = '0;
      end
      assign pair_in[j] = lo + hi;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pair_ff <= pair_in;
      end
   end

   logic signed [ovn_pkg::SUM_W-1:0] total_in;
   logic signed [ovn_pkg::SUM_W-1:0] total_ff;

   always_comb begin
      total_in = '0;
      for (int j = 0; j < NUM_PAIRS; j++) begin
         total_in = total_in + pair_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         total_ff <= total_in;
      end
   end

   localparam logic signed [ovn_pkg::SUM_W-1:0] SAT_HI = (ovn_pkg::SUM_W'(1) << 31) - 1;
   localparam logic signed [ovn_pkg::SUM_W-1:0] SAT_LO = -(ovn_pkg::SUM_W'(1) << 31);

   logic signed [ovn_pkg::OUT_W-1:0] sum_ff;
   logic                             sat_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (total_ff > SAT_HI) begin
            sum_ff <= SAT_HI[ovn_pkg::OUT_W-1:0];
            sat_ff <= 1'b1;
         end else if (total_ff < SAT_LO) begin
            sum_ff <= SAT_LO[ovn_pkg::OUT_W-1:0];
            sat_ff <= 1'b1;
         end else begin
            sum_ff <= total_ff[ovn_pkg::OUT_W-1:0];
            sat_ff <= 1'b0;
         end
      end
   end

   assign noise_sum = sum_ff;
   assign saturated = sat_ff;

endmodule

// ===== rtl/core/octave_value_noise_1d.sv =====
// Top level of the fractal 1-D value noise generator: lanes, amplitude table, sum.
// Depends on ovn_pkg, ovn_if, ovn_lane, ovn_amp and ovn_sum.
//
//   channel   direction   handshake            payload
//   req_chan  in          valid / ready        position (s32, Q16.16)
//   rsp_chan  out         valid / ready        noise_sum (s32, Q7.24), saturated
//   csr_*     in          csr_write_en only    csr_index, csr_wdata
//
// One position is accepted per cycle while the output is not stalled and the amplitude
// table is idle. Each result passes eleven register stages, eight in the octave lanes
// and three in the sum. After a persistence write the amplitude table refills through
// its single multiplier, and no beat is accepted meanwhile.
// A stalled output freezes the whole pipeline; bubbles are carried, never dropped.
// Reset is synchronous and restores octave_count 5 and persistence 1.0.
module octave_value_noise_1d #(
   parameter int unsigned MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ovn_pkg::CSR_DAT_W-1:0]     csr_wdata,
   ovn_req_if.sink                           req_chan,
   ovn_rsp_if.source                         rsp_chan
);

   // Octaves 0 and 1 share exponent 1, so one lane serves both.
   localparam int unsigned NUM_LANES = (MAX_OCTAVES > 1) ? MAX_OCTAVES - 1 : 1;

   logic [ovn_pkg::COUNT_W-1:0] octave_count_ff;
   logic                        amp_busy;
   ovn_pkg::amp_type            amp [NUM_LANES];
   ovn_pkg::contrib_type        contrib [NUM_LANES];
   ovn_pkg::contrib_type        oct_contrib [MAX_OCTAVES];
   logic [ovn_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic                        adv;
   logic                        take;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= ovn_pkg::OCTAVE_COUNT_RST;
      end else if (csr_write_en && csr_index == ovn_pkg::REG_OCTAVE_COUNT) begin
         octave_count_ff <= csr_wdata[ovn_pkg::COUNT_W-1:0];
      end
   end

   ovn_amp #(.NUM_LANES(NUM_LANES)) u_amp (
      .clock      (clock),
      .reset      (reset),
      .pers_write (csr_write_en && csr_index == ovn_pkg::REG_PERSISTENCE),
      .pers_data  (csr_wdata[ovn_pkg::PERS_W-1:0]),
      .amp        (amp),
      .busy       (amp_busy)
   );

   assign adv  = !valid_ff[ovn_pkg::PIPE_DEPTH-1] || rsp_chan.ready;
   assign take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = adv && !amp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ovn_pkg::PIPE_DEPTH-2:0], take};
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      ovn_lane #(.EXP(l + 1)) u_lane (
         .clock    (clock),
         .adv      (adv),
         .position (req_chan.position),
         .amp      (amp[l]),
         .contrib  (contrib[l])
      );
   end

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      assign oct_contrib[k] = contrib[(k > 0) ? k - 1 : 0];
   end

   ovn_sum #(.NUM_OCT(MAX_OCTAVES)) u_sum (
      .clock        (clock),
      .adv          (adv),
      .octave_count (octave_count_ff),
      .oct_contrib  (oct_contrib),
      .noise_sum    (rsp_chan.noise_sum),
      .saturated    (rsp_chan.saturated)
   );

   assign rsp_chan.valid = valid_ff[ovn_pkg::PIPE_DEPTH-1];

endmodule
